[sv/sphere_overlap_push_apart_top_defines.svh]
// Assertion macros for the sphere push-apart block.
`ifndef SPHERE_OVERLAP_PUSH_APART_TOP_DEFINES_SVH
`define SPHERE_OVERLAP_PUSH_APART_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SOPA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sopa assertion failed");
`define SOPA_ASSERT_AR(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sopa reset assertion failed");
`else
`define SOPA_ASSERT(lbl, prop)
`define SOPA_ASSERT_AR(lbl, prop)
`endif
`endif

[sv/sopa_pkg.sv]
// Shared constants for the sphere push-apart block.
`timescale 1ns / 1ps
package sopa_pkg;
    localparam int COORD_WIDTH_DEF = 32;
endpackage

[sv/sopa_isqrt.sv]
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module sopa_isqrt
    import sopa_pkg::*;
#(
    parameter int W = COORD_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [2*W-1:0]   radicand,
    output logic [W-1:0]     root
);
    localparam int RW = W + 2;

    logic [RW-1:0]  rem_reg  [W];
    logic [W-1:0]   root_reg [W];
    logic [2*W-1:0] x_reg    [W];

    genvar j;
    generate
        for (j = 0; j < W; j++)
        begin : g_stage
            logic [RW-1:0]  rem_in;
            logic [W-1:0]   root_in;
            logic [2*W-1:0] x_in;
            logic [RW+1:0]  t;
            logic [RW+1:0]  trial;
            logic [RW-1:0]  rem_next;
            logic [W-1:0]   root_next;

            if (j == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign x_in    = radicand;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[j-1];
                assign root_in = root_reg[j-1];
                assign x_in    = x_reg[j-1];
            end

            always_comb
            begin
                t     = {rem_in, x_in[2*W-1 -: 2]};
                trial = {{(RW+2-W-2){1'b0}}, root_in, 2'b01};
                if (t >= trial)
                begin
                    rem_next  = RW'(t - trial);
                    root_next = {root_in[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = RW'(t);
                    root_next = {root_in[W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j]  <= rem_next;
                    root_reg[j] <= root_next;
                    x_reg[j]    <= {x_in[2*W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign root = root_reg[W-1];
endmodule

[sv/sopa_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module sopa_div
    import sopa_pkg::*;
#(
    parameter int W = COORD_WIDTH_DEF
)
(
    input  logic           clk,
    input  logic           en,
    input  logic [2*W:0]   num,
    input  logic [W:0]     den,
    output logic [W-2:0]   quo
);
    localparam int QW = W - 1;
    localparam int RW = W + 2;

    logic [RW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] q_reg   [QW];
    logic [W:0]    den_reg [QW];

    genvar j;
    generate
        for (j = 0; j < QW; j++)
        begin : g_stage
            logic [RW-1:0] rem_in;
            logic [QW-1:0] low_in;
            logic [QW-1:0] q_in;
            logic [W:0]    den_in;
            logic [RW:0]   t;
            logic [RW-1:0] rem_next;
            logic          qb;

            if (j == 0)
            begin : g_first
                assign rem_in = num[2*W:QW];
                assign low_in = num[QW-1:0];
                assign q_in   = '0;
                assign den_in = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[j-1];
                assign low_in = low_reg[j-1];
                assign q_in   = q_reg[j-1];
                assign den_in = den_reg[j-1];
            end

            always_comb
            begin
                t = {rem_in, low_in[QW-1]};
                if (t >= {{(RW-W){1'b0}}, den_in})
                begin
                    rem_next = RW'(t - {{(RW-W){1'b0}}, den_in});
                    qb       = 1'b1;
                end
                else
                begin
                    rem_next = RW'(t);
                    qb       = 1'b0;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= rem_next;
                    low_reg[j] <= low_in << 1;
                    q_reg[j]   <= {q_in[QW-2:0], qb};
                    den_reg[j] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = q_reg[QW-1];
endmodule

[sv/sphere_overlap_push_apart_top.sv]
// Sphere pair overlap test and push-apart, fully pipelined.
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | a_x a_y a_z a_radius b_x b_y b_z b_radius
//  out     | out_valid/out_stall| new_a_* new_b_* overlapped
// One pair enters per cycle while the output is not stalled.
// Latency is set by the square root (one bit per stage) and the
// three dividers (one quotient bit per stage).
// Reset clears the valid bits only; payload registers are not reset.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "sphere_overlap_push_apart_top_defines.svh"
module sphere_overlap_push_apart_top
    import sopa_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] a_x,
    input  logic signed [COORD_WIDTH-1:0] a_y,
    input  logic signed [COORD_WIDTH-1:0] a_z,
    input  logic        [COORD_WIDTH-2:0] a_radius,
    input  logic signed [COORD_WIDTH-1:0] b_x,
    input  logic signed [COORD_WIDTH-1:0] b_y,
    input  logic signed [COORD_WIDTH-1:0] b_z,
    input  logic        [COORD_WIDTH-2:0] b_radius,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] new_a_x,
    output logic signed [COORD_WIDTH-1:0] new_a_y,
    output logic signed [COORD_WIDTH-1:0] new_a_z,
    output logic signed [COORD_WIDTH-1:0] new_b_x,
    output logic signed [COORD_WIDTH-1:0] new_b_y,
    output logic signed [COORD_WIDTH-1:0] new_b_z,
    output logic                          overlapped
);
    localparam int CW  = COORD_WIDTH;
    localparam int NV  = 2*CW + 3;
    localparam int ABW = 6*CW;
    localparam int MGW = 3*(CW+1);
    localparam int SQ0 = 3;
    localparam int MST = CW + 3;

    logic          en;
    logic [NV-1:0] valid_reg;
    logic          out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[NV-2:0], in_valid};
            out_valid_reg <= valid_reg[NV-1];
        end
    end

    // stage 1: differences and radius sum
    logic [ABW-1:0]      ab1_reg;
    logic signed [CW:0]  d1_reg [3];
    logic [CW-1:0]       rs1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ab1_reg   <= {b_z, b_y, b_x, a_z, a_y, a_x};
            d1_reg[0] <= (CW+1)'(b_x) - (CW+1)'(a_x);
            d1_reg[1] <= (CW+1)'(b_y) - (CW+1)'(a_y);
            d1_reg[2] <= (CW+1)'(b_z) - (CW+1)'(a_z);
            rs1_reg   <= {1'b0, a_radius} + {1'b0, b_radius};
        end
    end

    // stage 2: magnitudes and squares
    logic [ABW-1:0]  ab2_reg;
    logic [MGW-1:0]  mg2_reg;
    logic [2:0]      sg2_reg;
    logic [2*CW+1:0] sq2_reg [3];
    logic [2*CW-1:0] r2_reg;
    logic [CW-1:0]   rs2_reg;

    genvar k;
    generate
        for (k = 0; k < 3; k++)
        begin : g_sq
            logic [CW:0] m;
            assign m = d1_reg[k][CW] ? (CW+1)'(-d1_reg[k]) : d1_reg[k];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    mg2_reg[k*(CW+1) +: (CW+1)] <= m;
                    sg2_reg[k]                  <= d1_reg[k][CW];
                    sq2_reg[k]                  <= m * m;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ab2_reg <= ab1_reg;
            r2_reg  <= rs1_reg * rs1_reg;
            rs2_reg <= rs1_reg;
        end
    end

    // stage 3: squared distance and overlap test
    logic [2*CW+3:0] l2_sum;
    logic [ABW-1:0]  ab3_reg;
    logic [MGW-1:0]  mg3_reg;
    logic [2:0]      sg3_reg;
    logic [2*CW-1:0] l2_reg;
    logic [CW-1:0]   rs3_reg;
    logic            hit3_reg;
    logic            go3_reg;

    assign l2_sum = (2*CW+4)'(sq2_reg[0]) + (2*CW+4)'(sq2_reg[1])
                  + (2*CW+4)'(sq2_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ab3_reg  <= ab2_reg;
            mg3_reg  <= mg2_reg;
            sg3_reg  <= sg2_reg;
            rs3_reg  <= rs2_reg;
            l2_reg   <= l2_sum[2*CW-1:0];
            hit3_reg <= l2_sum < (2*CW+4)'(r2_reg);
            go3_reg  <= (l2_sum < (2*CW+4)'(r2_reg)) && (l2_sum != '0);
        end
    end

    // square root with side data alongside
    logic [CW-1:0]  root_dist;
    logic [ABW-1:0] abq_reg [CW];
    logic [MGW-1:0] mgq_reg [CW];
    logic [CW-1:0]  rsq_reg [CW];
    logic [4:0]     flq_reg [CW];

    sopa_isqrt #(.W(CW)) u_isqrt
    (
        .clk      (clk),
        .en       (en),
        .radicand (l2_reg),
        .root     (root_dist)
    );

    generate
        for (k = 0; k < CW; k++)
        begin : g_sqside
            if (k == 0)
            begin : g_head
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        abq_reg[k] <= ab3_reg;
                        mgq_reg[k] <= mg3_reg;
                        rsq_reg[k] <= rs3_reg;
                        flq_reg[k] <= {hit3_reg, go3_reg, sg3_reg};
                    end
                end
            end
            else
            begin : g_tail
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        abq_reg[k] <= abq_reg[k-1];
                        mgq_reg[k] <= mgq_reg[k-1];
                        rsq_reg[k] <= rsq_reg[k-1];
                        flq_reg[k] <= flq_reg[k-1];
                    end
                end
            end
        end
    endgenerate

    // overlap depth and dividends
    logic [CW-1:0]  s_dep;
    logic [ABW-1:0] abm_reg;
    logic [4:0]     flm_reg;
    logic [2*CW:0]  num_reg [3];
    logic [CW:0]    den_reg;

    assign s_dep = rsq_reg[CW-1] - root_dist;

    generate
        for (k = 0; k < 3; k++)
        begin : g_num
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[k] <= mgq_reg[CW-1][k*(CW+1) +: (CW+1)] * s_dep;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abm_reg <= abq_reg[CW-1];
            flm_reg <= flq_reg[CW-1];
            den_reg <= {root_dist, 1'b0};
        end
    end

    // dividers with side data alongside
    logic [CW-2:0]  quo [3];
    logic [ABW-1:0] abv_reg [CW-1];
    logic [4:0]     flv_reg [CW-1];

    generate
        for (k = 0; k < 3; k++)
        begin : g_div
            sopa_div #(.W(CW)) u_div
            (
                .clk (clk),
                .en  (en),
                .num (num_reg[k]),
                .den (den_reg),
                .quo (quo[k])
            );
        end
        for (k = 0; k < CW-1; k++)
        begin : g_dvside
            if (k == 0)
            begin : g_head
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        abv_reg[k] <= abm_reg;
                        flv_reg[k] <= flm_reg;
                    end
                end
            end
            else
            begin : g_tail
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        abv_reg[k] <= abv_reg[k-1];
                        flv_reg[k] <= flv_reg[k-1];
                    end
                end
            end
        end
    endgenerate

    // apply push and saturate
    logic [ABW-1:0] ab_fin;
    logic [4:0]     fl_fin;
    logic [CW-1:0]  na_next [3];
    logic [CW-1:0]  nb_next [3];
    logic [CW-1:0]  na_reg  [3];
    logic [CW-1:0]  nb_reg  [3];
    logic           ovl_reg;

    assign ab_fin = abv_reg[CW-2];
    assign fl_fin = flv_reg[CW-2];

    generate
        for (k = 0; k < 3; k++)
        begin : g_fin
            logic signed [CW:0] q;
            logic signed [CW:0] av;
            logic signed [CW:0] bv;
            logic signed [CW:0] na;
            logic signed [CW:0] nb;
            assign q  = fl_fin[3] ? {2'b00, quo[k]} : '0;
            assign av = (CW+1)'($signed(ab_fin[k*CW +: CW]));
            assign bv = (CW+1)'($signed(ab_fin[(k+3)*CW +: CW]));
            assign na = fl_fin[k] ? av + q : av - q;
            assign nb = fl_fin[k] ? bv - q : bv + q;
            assign na_next[k] = (na[CW] != na[CW-1]) ? {na[CW], {(CW-1){~na[CW]}}}
                                                     : na[CW-1:0];
            assign nb_next[k] = (nb[CW] != nb[CW-1]) ? {nb[CW], {(CW-1){~nb[CW]}}}
                                                     : nb[CW-1:0];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    na_reg[k] <= na_next[k];
                    nb_reg[k] <= nb_next[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovl_reg <= fl_fin[4];
        end
    end

    assign out_valid  = out_valid_reg;
    assign new_a_x    = na_reg[0];
    assign new_a_y    = na_reg[1];
    assign new_a_z    = na_reg[2];
    assign new_b_x    = nb_reg[0];
    assign new_b_y    = nb_reg[1];
    assign new_b_z    = nb_reg[2];
    assign overlapped = ovl_reg;

    `SOPA_ASSERT(a_accept_enters, (in_valid && !in_stall) |=> valid_reg[0])
    `SOPA_ASSERT(a_freeze_holds, !en |=> $stable(valid_reg))
    `SOPA_ASSERT(a_last_to_out, (en && valid_reg[NV-1]) |=> out_valid_reg)
    `SOPA_ASSERT_AR(a_reset_empty, !rst_n |-> (valid_reg == '0 && !out_valid_reg))
endmodule
